>>> src/sm4_pkg.sv
// SM4 package: S-box, FK/CK constants, S-box substitution, L and L' transforms.
// No dependencies.
`default_nettype none
package sm4_pkg;
  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned Rounds = 32;
  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  localparam logic [31:0] Fk [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] Sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // CK byte j of word i is (4*i + j) * 7 mod 256
  function automatic logic [31:0] ck(input logic [4:0] i);
    logic [7:0] b;
    logic [31:0] r;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'(({i, 2'b00} + 7'(j)) * 8'd7);
      r[31-8*j -: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [31:0] subst(input logic [31:0] v);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) r[8*b +: 8] = Sbox[v[8*b +: 8]];
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] l_data(input logic [31:0] s);
    return s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
  endfunction

  function automatic logic [31:0] l_key(input logic [31:0] s);
    return s ^ rotl(s, 13) ^ rotl(s, 23);
  endfunction
endpackage
`default_nettype wire

>>> src/sm4_round.sv
// One pipeline stage: one key-schedule step and one data round.
// Depends on sm4_pkg.
`default_nettype none
module sm4_round import sm4_pkg::*; #(
  parameter logic [4:0] Idx = 5'd0
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [127:0] key_i,
  input  wire logic [127:0] dat_i,
  output logic      [127:0] key_o,
  output logic      [127:0] dat_o
);
  logic [31:0] rk;
  logic [31:0] xw;
  logic [127:0] key_q, dat_q;

  always_comb begin
    rk = key_i[127:96] ^ l_key(subst(key_i[95:64] ^ key_i[63:32] ^ key_i[31:0] ^ ck(Idx)));
    xw = dat_i[127:96] ^ l_data(subst(dat_i[95:64] ^ dat_i[63:32] ^ dat_i[31:0] ^ rk));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= {key_i[95:0], rk};
      dat_q <= {dat_i[95:0], xw};
    end
  end

  assign key_o = key_q;
  assign dat_o = dat_q;
endmodule
`default_nettype wire

>>> src/sm4_block_encrypt.sv
// SM4 encrypt top: key registers, 32-stage round pipeline, output skid-free stall.
// Depends on sm4_pkg and sm4_round.
//
// Usage:
//   Write key_high at index 0 and key_low at index 1 on cfg_we_i/cfg_idx_i/
//   cfg_wdata_i while no block is in flight. The key schedule is computed
//   alongside each block, so a new key applies to the next block at once.
//   s_axis carries plaintext in tdata, m_axis returns ciphertext in tdata.
//   Each accepted transaction passes through the round stages in order,
//   each stage holding one key step and one data round.
//   Throughput: one block per cycle while not stalled; 32 rounds unrolled into stages.
//   Stall: when m_axis_tready is low the full stages at the output hold and
//   earlier stages still advance; s_axis_tready falls only if every stage
//   is full and the last is not taken, so bubbles are filled.
//   Reset: valid bits and keys clear; any in-flight data is dropped.
//
`default_nettype none
module sm4_block_encrypt import sm4_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [63:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // block_low, block_high
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata    // cipher_low, cipher_high
);
  logic [63:0] key_high_q, key_low_q;
  logic [Rounds:0] vld_q;
  logic [Rounds:0] en;
  logic [127:0] key_s [Rounds+1];
  logic [127:0] dat_s [Rounds+1];
  logic [127:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeyHigh: key_high_q <= cfg_wdata_i;
        RegKeyLow:  key_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage k advances when its successor can take data
  always_comb begin
    en[Rounds] = m_axis_tready || !vld_q[Rounds];
    for (int k = Rounds - 1; k >= 0; k--) en[k] = en[k+1] || !vld_q[k+1];
  end

  assign s_axis_tready = en[0];
  assign key_s[0] = {key_high_q ^ {Fk[0], Fk[1]}, key_low_q ^ {Fk[2], Fk[3]}};
  assign dat_s[0] = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= 1'b0;
      for (int k = 1; k <= Rounds; k++)
        if (en[k-1]) vld_q[k] <= (k == 1) ? s_axis_tvalid : vld_q[k-1];
    end
  end

  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    sm4_round #(.Idx(5'(g))) u_rnd (
      .clk_i (clk_i),
      .en_i  (en[g]),
      .key_i (key_s[g]),
      .dat_i (dat_s[g]),
      .key_o (key_s[g+1]),
      .dat_o (dat_s[g+1])
    );
  end

  assign res = dat_s[Rounds];
  assign m_axis_tvalid = vld_q[Rounds];
  // reverse word order; high half in low tdata bits
  assign m_axis_tdata = {res[95:64], res[127:96], res[31:0], res[63:32]};
endmodule
`default_nettype wire
